// ===== src/csaa_pkg.sv =====
// shared types and constants for the shift-and-add accumulator
package csaa_pkg;

  localparam int MAX_CONV   = 8;
  localparam int MAX_WORDS  = 4;
  localparam int COL_MASK_W = 32;
  localparam int ADC_W      = 8;

  localparam logic [2:0] OP_ADC_DONE  = 3'd0;
  localparam logic [2:0] OP_IADD      = 3'd1;
  localparam logic [2:0] OP_COPY_ADC  = 3'd2;
  localparam logic [2:0] OP_ADDER_SEL = 3'd3;
  localparam logic [2:0] OP_COPY_OUT  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COLS,
    ST_MERGE,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_COL,
    CMD_IADD,
    CMD_CP,
    CMD_MERGE,
    CMD_EMIT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic       load;
    logic [4:0] col;
    logic [4:0] adc;
    logic [4:0] place;
    logic [2:0] lane;
    logic [2:0] pos;
    logic [2:0] word;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/csaa_ctrl.sv =====
// controller: sequences columns, merge lanes and word emission
module csaa_ctrl import csaa_pkg::*; #(
  parameter int NUM_CONVERTERS = 8,
  parameter int GROUP          = 4,
  parameter int WORD_BITS      = 8,
  parameter int PER            = 2,
  parameter int NUM_WORDS      = 4,
  parameter int NCOL_EFF       = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_opcode,
  output logic       in_stall,
  input  dp_status_t status,
  output cmd_t       cmd
);

  state_t     state_r, state_nxt;
  logic [4:0] col_r, col_nxt;
  logic [4:0] grp_r, grp_nxt;
  logic [4:0] wbp_r, wbp_nxt;
  logic [4:0] adc_r, adc_nxt;
  logic [2:0] lane_r, lane_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic [2:0] word_r, word_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
      grp_r   <= '0;
      wbp_r   <= '0;
      adc_r   <= '0;
      lane_r  <= '0;
      pos_r   <= '0;
      word_r  <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      grp_r   <= grp_nxt;
      wbp_r   <= wbp_nxt;
      adc_r   <= adc_nxt;
      lane_r  <= lane_nxt;
      pos_r   <= pos_nxt;
      word_r  <= word_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    grp_nxt   = grp_r;
    wbp_nxt   = wbp_r;
    adc_nxt   = adc_r;
    lane_nxt  = lane_r;
    pos_nxt   = pos_r;
    word_nxt  = word_r;
    in_stall  = (state_r != ST_IDLE);
    cmd       = '0;
    cmd.op    = CMD_NONE;
    cmd.col   = col_r;
    cmd.adc   = adc_r;
    cmd.place = (WORD_BITS >= GROUP) ? grp_r : wbp_r;
    cmd.lane  = lane_r;
    cmd.pos   = pos_r;
    cmd.word  = word_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_opcode)
            OP_ADC_DONE: begin
              state_nxt = ST_COLS;
              col_nxt   = '0;
              grp_nxt   = '0;
              wbp_nxt   = '0;
              adc_nxt   = '0;
            end
            OP_IADD:     cmd.op = CMD_IADD;
            OP_COPY_ADC: cmd.op = CMD_CP;
            OP_ADDER_SEL: begin
              state_nxt = ST_MERGE;
              lane_nxt  = '0;
              pos_nxt   = '0;
              word_nxt  = '0;
            end
            OP_COPY_OUT: begin
              state_nxt = ST_EMIT;
              word_nxt  = 3'(NUM_WORDS - 1);
            end
            default: ;
          endcase
        end
      end
      ST_COLS: begin
        cmd.op = CMD_COL;
        if (col_r == 5'(NCOL_EFF - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          col_nxt = col_r + 5'd1;
          // column place within its adc group and within a word
          if ({4'b0, grp_r} == 9'(GROUP - 1)) begin
            grp_nxt = '0;
            adc_nxt = adc_r + 5'd1;
          end else begin
            grp_nxt = grp_r + 5'd1;
          end
          if (wbp_r == 5'(WORD_BITS - 1)) wbp_nxt = '0;
          else                             wbp_nxt = wbp_r + 5'd1;
        end
      end
      ST_MERGE: begin
        cmd.op = CMD_MERGE;
        if (lane_r == 3'(NUM_CONVERTERS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          lane_nxt = lane_r + 3'd1;
          if ({3'b0, pos_r} == 6'(PER - 1)) begin
            pos_nxt  = '0;
            word_nxt = word_r + 3'd1;
          end else begin
            pos_nxt = pos_r + 3'd1;
          end
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.op = CMD_EMIT;
          if (word_r == 3'd0) state_nxt = ST_IDLE;
          else                word_nxt  = word_r - 3'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== src/csaa_dp.sv =====
// datapath: partial sums, bit accumulators, adc results, word sums, output register
module csaa_dp import csaa_pkg::*; #(
  parameter int NUM_CONVERTERS = 8,
  parameter int GROUP          = 4,
  parameter int PER            = 2,
  parameter int NUM_WORDS      = 4,
  parameter int SUM_BITS       = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  logic [COL_MASK_W-1:0] in_column_mask,
  input  logic [MAX_CONV-1:0]   in_merge_mask,
  input  logic [ADC_W-1:0]      in_adc_value [MAX_CONV],
  output dp_status_t            status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_word_index,
  output logic [31:0]           out_word_sum,
  output logic                  out_last_word
);

  logic [COL_MASK_W-1:0] col_mask_r;
  logic [MAX_CONV-1:0]   merge_mask_r;
  logic [ADC_W-1:0]      adc_val_r [MAX_CONV];
  logic [SUM_BITS-1:0]   partial_r [MAX_CONV];
  logic [SUM_BITS-1:0]   bacc_r    [MAX_CONV];
  logic [SUM_BITS-1:0]   res_r     [MAX_CONV];
  logic [SUM_BITS-1:0]   wacc_r    [MAX_WORDS];
  logic [5:0]            bitpos_r;
  logic                  out_valid_r;
  logic [1:0]            out_idx_r;
  logic [31:0]           out_sum_r;
  logic                  out_last_r;

  logic                col_hit;
  logic [SUM_BITS-1:0] col_term;
  logic                mrg_hit;
  logic [5:0]          mrg_shift;
  logic [SUM_BITS-1:0] mrg_term;

  assign col_hit  = col_mask_r[cmd.col] && (cmd.adc < 5'(NUM_CONVERTERS));
  assign col_term = {{(SUM_BITS-ADC_W){1'b0}}, adc_val_r[cmd.adc[2:0]]} << cmd.place;

  assign mrg_hit   = merge_mask_r[cmd.lane] && (cmd.word < 3'(NUM_WORDS));
  assign mrg_shift = 6'(GROUP * (PER - 1 - int'(cmd.pos)));
  assign mrg_term  = res_r[cmd.lane] << mrg_shift;

  assign status.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_mask_r   <= in_column_mask;
      merge_mask_r <= in_merge_mask;
      adc_val_r    <= in_adc_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CONV; i++) begin
        partial_r[i] <= '0;
        bacc_r[i]    <= '0;
        res_r[i]     <= '0;
      end
      for (int w = 0; w < MAX_WORDS; w++) wacc_r[w] <= '0;
      bitpos_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == CMD_EMIT) out_valid_r <= 1'b1;
      else if (!out_stall)    out_valid_r <= 1'b0;

      case (cmd.op)
        CMD_COL: begin
          if (col_hit) partial_r[cmd.adc[2:0]] <= partial_r[cmd.adc[2:0]] + col_term;
        end
        CMD_IADD: begin
          for (int i = 0; i < MAX_CONV; i++) begin
            bacc_r[i]    <= bacc_r[i] + (partial_r[i] << bitpos_r);
            partial_r[i] <= '0;
          end
          bitpos_r <= bitpos_r + 6'd1;
        end
        CMD_CP: begin
          for (int i = 0; i < MAX_CONV; i++) begin
            res_r[i]  <= bacc_r[i];
            bacc_r[i] <= '0;
          end
          bitpos_r <= '0;
        end
        CMD_MERGE: begin
          if (mrg_hit) wacc_r[cmd.word[1:0]] <= wacc_r[cmd.word[1:0]] + mrg_term;
        end
        CMD_EMIT: begin
          wacc_r[cmd.word[1:0]] <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_EMIT) begin
      out_idx_r  <= cmd.word[1:0];
      out_sum_r  <= 32'(wacc_r[cmd.word[1:0]]);
      out_last_r <= (cmd.word == 3'd0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_word_index = out_idx_r;
  assign out_word_sum   = out_sum_r;
  assign out_last_word  = out_last_r;

endmodule

// ===== src/cim_shift_add_accumulator_core.sv =====
// shift-and-add accumulator for compute-in-memory adc outputs, top level
// iadd, cp and unknown opcodes leave the controller idle; adc-done walks min(NUM_COLUMNS,32) columns,
// one column per cycle through a single shift-add unit; adder select walks NUM_CONVERTERS
// adc lanes, one lane per cycle; copy out emits NUM_WORDS words and is held by any output stall
// words go from the emit state through the output register, one word per cycle when not stalled
// synchronous active-low reset clears all sums, the bit count and the controller
module cim_shift_add_accumulator_core import csaa_pkg::*; #(
  parameter int NUM_COLUMNS    = 32,
  parameter int NUM_CONVERTERS = 8,
  parameter int WORD_BITS      = 8,
  parameter int SUM_BITS       = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_column_mask,
  input  logic [7:0]  in_merge_mask,
  input  logic [7:0]  in_adc_value_0,
  input  logic [7:0]  in_adc_value_1,
  input  logic [7:0]  in_adc_value_2,
  input  logic [7:0]  in_adc_value_3,
  input  logic [7:0]  in_adc_value_4,
  input  logic [7:0]  in_adc_value_5,
  input  logic [7:0]  in_adc_value_6,
  input  logic [7:0]  in_adc_value_7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_word_index,
  output logic [31:0] out_word_sum,
  output logic        out_last_word
);

  localparam int GroupRaw  = NUM_COLUMNS / NUM_CONVERTERS;
  localparam int Group     = (GroupRaw < 1) ? 1 : GroupRaw;
  localparam int PerRaw    = WORD_BITS / Group;
  localparam int Per       = (PerRaw < 1) ? 1 : PerRaw;
  localparam int WordsRaw  = NUM_COLUMNS / WORD_BITS;
  localparam int NumWords  = (WordsRaw < 1) ? 1 : ((WordsRaw > MAX_WORDS) ? MAX_WORDS : WordsRaw);
  localparam int NcolEff   = (NUM_COLUMNS > COL_MASK_W) ? COL_MASK_W : NUM_COLUMNS;

  cmd_t             cmd;
  dp_status_t       status;
  logic [ADC_W-1:0] adc_vals [MAX_CONV];

  assign adc_vals[0] = in_adc_value_0;
  assign adc_vals[1] = in_adc_value_1;
  assign adc_vals[2] = in_adc_value_2;
  assign adc_vals[3] = in_adc_value_3;
  assign adc_vals[4] = in_adc_value_4;
  assign adc_vals[5] = in_adc_value_5;
  assign adc_vals[6] = in_adc_value_6;
  assign adc_vals[7] = in_adc_value_7;

  csaa_ctrl #(
    .NUM_CONVERTERS(NUM_CONVERTERS),
    .GROUP         (Group),
    .WORD_BITS     (WORD_BITS),
    .PER           (Per),
    .NUM_WORDS     (NumWords),
    .NCOL_EFF      (NcolEff)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_opcode(in_opcode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  csaa_dp #(
    .NUM_CONVERTERS(NUM_CONVERTERS),
    .GROUP         (Group),
    .PER           (Per),
    .NUM_WORDS     (NumWords),
    .SUM_BITS      (SUM_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_column_mask(in_column_mask),
    .in_merge_mask (in_merge_mask),
    .in_adc_value  (adc_vals),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word_index(out_word_index),
    .out_word_sum  (out_word_sum),
    .out_last_word (out_last_word)
  );

  // the last word of a copy out run is always word zero
  a_last_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_word |-> out_word_index == 2'd0)
    else $error("last word flagged on nonzero index");

  // multi-cycle opcodes hold off the next transaction
  a_busy_after_multi: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode == OP_ADC_DONE || in_opcode == OP_ADDER_SEL ||
      in_opcode == OP_COPY_OUT) |=> in_stall)
    else $error("controller did not go busy");

  // results are only loaded while the controller is emitting
  a_emit_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result produced outside copy out");

endmodule

// ===== test/cim_shift_add_accumulator_core_test.sv =====
// self-checking testbench for the cim shift-and-add accumulator core
`timescale 1ns / 1ps

module cim_shift_add_accumulator_core_test;
  import csaa_pkg::*;

  localparam int N_COLS   = 32;
  localparam int N_CONV   = 8;
  localparam int WBITS    = 8;
  localparam int GRP      = (N_COLS / N_CONV < 1) ? 1 : N_COLS / N_CONV;
  localparam int PER_WORD = (WBITS / GRP < 1) ? 1 : WBITS / GRP;
  localparam int N_WORDS  = (N_COLS / WBITS < 1) ? 1 :
                            ((N_COLS / WBITS > 4) ? 4 : N_COLS / WBITS);

  localparam logic [2:0] OP_RESERVED_LO = 3'd5;
  localparam logic [2:0] OP_RESERVED_HI = 3'd7;

  typedef struct packed {
    logic [2:0]      op;
    logic [31:0]     cols;
    logic [7:0]      merge;
    logic [7:0][7:0] adc;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] sum;
    logic        last;
  } word_out_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_opcode;
  logic [31:0] in_column_mask;
  logic [7:0]  in_merge_mask;
  logic [7:0]  in_adc_value_0, in_adc_value_1, in_adc_value_2, in_adc_value_3;
  logic [7:0]  in_adc_value_4, in_adc_value_5, in_adc_value_6, in_adc_value_7;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_word_index;
  logic [31:0] out_word_sum;
  logic        out_last_word;

  // shadow state of the accumulator
  logic [31:0] lane_psum   [N_CONV];
  logic [31:0] lane_acc    [N_CONV];
  logic [31:0] lane_result [N_CONV];
  logic [31:0] word_total  [N_WORDS];
  logic [5:0]  input_bit;

  word_out_t   pending_words[$];
  int          errors;
  int          useful_items;
  int          words_checked;
  int          copy_outs;
  int          max_bit_seen;
  bit          idle_on;

  cim_shift_add_accumulator_core #(
    .NUM_COLUMNS   (N_COLS),
    .NUM_CONVERTERS(N_CONV),
    .WORD_BITS     (WBITS),
    .SUM_BITS      (32)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_column_mask(in_column_mask),
    .in_merge_mask (in_merge_mask),
    .in_adc_value_0(in_adc_value_0),
    .in_adc_value_1(in_adc_value_1),
    .in_adc_value_2(in_adc_value_2),
    .in_adc_value_3(in_adc_value_3),
    .in_adc_value_4(in_adc_value_4),
    .in_adc_value_5(in_adc_value_5),
    .in_adc_value_6(in_adc_value_6),
    .in_adc_value_7(in_adc_value_7),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word_index(out_word_index),
    .out_word_sum  (out_word_sum),
    .out_last_word (out_last_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // works out the words a transaction produces and updates the shadow state
  function automatic void accumulate_item(cmd_item_t it);
    int adc;
    int place;
    int w;
    word_out_t wo;
    case (it.op)
      OP_ADC_DONE: begin
        for (int j = 0; j < 32; j++) begin
          adc = j / GRP;
          place = (WBITS >= GRP) ? j % GRP : j % WBITS;
          if (it.cols[j] && j < N_COLS && adc < N_CONV)
            lane_psum[adc] = lane_psum[adc] + (32'(it.adc[adc]) << place);
        end
      end
      OP_IADD: begin
        for (int i = 0; i < N_CONV; i++) begin
          // shifts of 32 and beyond drop everything
          lane_acc[i] = lane_acc[i] + (lane_psum[i] << input_bit);
          lane_psum[i] = '0;
        end
        input_bit = input_bit + 6'd1;
        if (int'(input_bit) > max_bit_seen) max_bit_seen = int'(input_bit);
      end
      OP_COPY_ADC: begin
        for (int i = 0; i < N_CONV; i++) begin
          lane_result[i] = lane_acc[i];
          lane_acc[i] = '0;
        end
        input_bit = '0;
      end
      OP_ADDER_SEL: begin
        for (int i = 0; i < N_CONV; i++) begin
          w = i / PER_WORD;
          if (it.merge[i] && w < N_WORDS)
            word_total[w] = word_total[w] +
                            (lane_result[i] << (GRP * (PER_WORD - 1 - i % PER_WORD)));
        end
      end
      OP_COPY_OUT: begin
        copy_outs++;
        for (int k = N_WORDS - 1; k >= 0; k--) begin
          wo.index = 2'(k);
          wo.sum   = word_total[k];
          wo.last  = (k == 0);
          pending_words.push_back(wo);
          word_total[k] = '0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 10)
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    word_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: word %0d = 0x%0h arrived with none pending", $realtime,
                   out_word_index, out_word_sum);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (out_word_index !== want.index)
          note_mismatch("word_index", 32'(want.index), 32'(out_word_index));
        if (out_word_sum !== want.sum) note_mismatch("word_sum", want.sum, out_word_sum);
        if (out_last_word !== want.last)
          note_mismatch("last_word", 32'(want.last), 32'(out_last_word));
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_stall <= idle_on && ($urandom_range(99) < 30);
  end

  function automatic cmd_item_t make_item(logic [2:0] op, logic [31:0] cols,
                                          logic [7:0] merge, logic [7:0][7:0] adc);
    cmd_item_t it;
    it.op = op;
    it.cols = cols;
    it.merge = merge;
    it.adc = adc;
    return it;
  endfunction

  function automatic logic [31:0] rand_cols();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 32'hFFFF_FFFF;
    if (pick == 1) return '0;
    return $urandom;
  endfunction

  function automatic logic [7:0][7:0] rand_adcs();
    logic [7:0][7:0] v;
    bit extremes;
    extremes = ($urandom_range(4) == 0);
    for (int i = 0; i < 8; i++)
      v[i] = extremes ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom);
    return v;
  endfunction

  // caller is at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(cmd_item_t it);
    int gap;
    gap = (idle_on && $urandom_range(99) < 30) ? $urandom_range(4, 1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode      <= it.op;
    in_column_mask <= it.cols;
    in_merge_mask  <= it.merge;
    in_adc_value_0 <= it.adc[0];
    in_adc_value_1 <= it.adc[1];
    in_adc_value_2 <= it.adc[2];
    in_adc_value_3 <= it.adc[3];
    in_adc_value_4 <= it.adc[4];
    in_adc_value_5 <= it.adc[5];
    in_adc_value_6 <= it.adc[6];
    in_adc_value_7 <= it.adc[7];
    in_valid       <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accumulate_item(it);
    if (it.op <= OP_COPY_OUT) useful_items++;
    @(negedge clk);
  endtask

  task automatic send_op(logic [2:0] op);
    send_item(make_item(op, rand_cols(), 8'($urandom), rand_adcs()));
  endtask

  task automatic maybe_noise();
    if ($urandom_range(99) < 12)
      send_item(make_item(3'($urandom_range(7)), $urandom, 8'($urandom), rand_adcs()));
  endtask

  task automatic wait_for_words();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_words.size() != 0) @(negedge clk);
  endtask

  // one multi-bit dot product: per input bit some conversions then iadd, then cp, as, cb
  task automatic run_bit_serial_pass();
    int bits;
    bits = $urandom_range(8, 1);
    for (int b = 0; b < bits; b++) begin
      repeat ($urandom_range(2, 1)) begin
        maybe_noise();
        send_op(OP_ADC_DONE);
      end
      send_op(OP_IADD);
    end
    maybe_noise();
    send_op(OP_COPY_ADC);
    repeat ($urandom_range(2, 1)) begin
      send_item(make_item(OP_ADDER_SEL, rand_cols(),
                          $urandom_range(3) == 0 ? 8'hFF : 8'($urandom), rand_adcs()));
    end
    maybe_noise();
    send_op(OP_COPY_OUT);
  endtask

  task automatic test_directed();
    logic [7:0][7:0] ramp;
    for (int i = 0; i < 8; i++) ramp[i] = 8'(1 << i);
    send_item(make_item(OP_ADC_DONE, 32'hFFFF_FFFF, 8'h00, {8{8'hFF}}));
    send_item(make_item(OP_ADC_DONE, 32'h0000_0000, 8'hFF, {8{8'hFF}}));
    send_item(make_item(OP_IADD, 32'hFFFF_FFFF, 8'hFF, {8{8'hFF}}));
    send_item(make_item(OP_ADC_DONE, 32'h8000_0001, 8'h00, ramp));
    send_item(make_item(OP_ADC_DONE, 32'hFFFF_FFFF, 8'h00, {8{8'h00}}));
    send_item(make_item(OP_ADC_DONE, 32'h1248_8421, 8'h00, ramp));
    send_item(make_item(OP_IADD, 32'h0, 8'h00, {8{8'h00}}));
    send_item(make_item(OP_IADD, 32'h0, 8'h00, {8{8'h00}}));
    send_item(make_item(OP_COPY_ADC, 32'h0, 8'h00, {8{8'h00}}));
    send_item(make_item(OP_ADDER_SEL, 32'h0, 8'hFF, {8{8'h00}}));
    send_item(make_item(OP_COPY_OUT, 32'h0, 8'h00, {8{8'h00}}));
    // a second copy out right away must give cleared words
    send_item(make_item(OP_COPY_OUT, 32'hFFFF_FFFF, 8'hFF, {8{8'hFF}}));
    send_item(make_item(OP_ADDER_SEL, 32'h0, 8'h55, {8{8'h00}}));
    send_item(make_item(OP_ADDER_SEL, 32'h0, 8'hAA, {8{8'h00}}));
    send_item(make_item(OP_ADDER_SEL, 32'h0, 8'h00, {8{8'h00}}));
    send_item(make_item(OP_COPY_OUT, 32'h0, 8'h00, {8{8'h00}}));
    // reserved opcodes must leave every sum alone
    for (logic [3:0] op = 4'(OP_RESERVED_LO); op <= 4'(OP_RESERVED_HI); op++)
      send_item(make_item(3'(op), 32'hFFFF_FFFF, 8'hFF, {8{8'hFF}}));
    send_item(make_item(OP_ADDER_SEL, 32'h0, 8'h0F, {8{8'h00}}));
    send_item(make_item(OP_COPY_ADC, 32'h0, 8'h00, {8{8'h00}}));
    send_item(make_item(OP_ADDER_SEL, 32'h0, 8'hFF, {8{8'h00}}));
    send_item(make_item(OP_COPY_OUT, 32'h0, 8'h00, {8{8'h00}}));
  endtask

  // drive the bit count past the sum width and around its 6-bit wrap
  task automatic test_bit_count_wrap();
    for (int k = 0; k < 70; k++) begin
      if (k % 9 == 0 || (k >= 27 && k <= 33) || k >= 62)
        send_item(make_item(OP_ADC_DONE, 32'hFFFF_FFFF, 8'h00, rand_adcs()));
      send_op(OP_IADD);
    end
    send_op(OP_COPY_ADC);
    send_item(make_item(OP_ADDER_SEL, 32'h0, 8'hFF, {8{8'h00}}));
    send_op(OP_COPY_OUT);
  endtask

  task automatic test_pause_for_results();
    run_bit_serial_pass();
    wait_for_words();
    run_bit_serial_pass();
  endtask

  task automatic test_back_to_back();
    int stop_at;
    stop_at = useful_items + 30;
    idle_on = 1'b0;
    while (useful_items < stop_at) run_bit_serial_pass();
    idle_on = 1'b1;
  endtask

  task automatic test_random_passes();
    int stop_at;
    stop_at = useful_items + 25;
    while (useful_items < stop_at) run_bit_serial_pass();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_ADC_DONE;
    in_column_mask = '0;
    in_merge_mask  = '0;
    in_adc_value_0 = '0;
    in_adc_value_1 = '0;
    in_adc_value_2 = '0;
    in_adc_value_3 = '0;
    in_adc_value_4 = '0;
    in_adc_value_5 = '0;
    in_adc_value_6 = '0;
    in_adc_value_7 = '0;
    out_stall      = 1'b0;
    errors         = 0;
    useful_items   = 0;
    words_checked  = 0;
    copy_outs      = 0;
    max_bit_seen   = 0;
    idle_on        = 1'b1;
    for (int i = 0; i < N_CONV; i++) begin
      lane_psum[i]   = '0;
      lane_acc[i]    = '0;
      lane_result[i] = '0;
    end
    for (int w = 0; w < N_WORDS; w++) word_total[w] = '0;
    input_bit = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_bit_count_wrap();
    test_pause_for_results();
    test_back_to_back();
    test_random_passes();

    wait_for_words();
    repeat (40) @(negedge clk);
    $display("sent %0d transactions, checked %0d words from %0d copy-outs", useful_items,
             words_checked, copy_outs);
    $display("bit count reached %0d before wrapping, with gaps and stalls on both sides",
             max_bit_seen);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
